@@ hdl/xs1024_pkg.sv @@
// Package with item types, request codes, constants and the step function of the generator.
`default_nettype none

package xs1024_pkg;

    // Request codes carried in req_type
    localparam logic [2:0] REQ_DRAW_WORD = 3'd0;
    localparam logic [2:0] REQ_WRITE     = 3'd1;
    localparam logic [2:0] REQ_JUMP      = 3'd2;
    localparam logic [2:0] REQ_DRAW_BIT  = 3'd3;
    localparam logic [2:0] REQ_SET_PTR   = 3'd4;

    // Output scrambler multiplier and its 32-bit halves
    localparam logic [63:0] PHI_MULT    = 64'h9e3779b97f4a7c13;
    localparam logic [31:0] PHI_MULT_LO = PHI_MULT[31:0];
    localparam logic [31:0] PHI_MULT_HI = PHI_MULT[63:32];

    // Jump polynomial for an advance of 2^512 steps, lowest word first
    localparam logic [63:0] JUMP_POLY [16] = '{
        64'h84242f96eca9c41d, 64'ha3c65b8776f96855, 64'h5b34a39f070b5837,
        64'h4489affce4f31a1e, 64'h2ffeeb0a48316f40, 64'hdc2d9891fe68c022,
        64'h3659132bb12fea70, 64'haac17d8efa43cab8, 64'hc4cb815590989b13,
        64'h5ee975283d71c93b, 64'h691548c86c1bd540, 64'h7910c41d10a1e6a5,
        64'h0b5fc64563b3e2a8, 64'h047f7684e9fc949d, 64'hb99181f2d8f685ca,
        64'h284600e3f30e38c3
    };

    // Input item
    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  word_index;
        logic [63:0] word_value;
    } req_t;

    // Result item
    typedef struct packed {
        logic [63:0] random_word;
        logic        random_bit;
    } res_t;

    // Write port of a 16-entry state memory
    typedef struct packed {
        logic        en;
        logic [3:0]  addr;
        logic [63:0] data;
    } wr_port_t;

    // One xorshift1024 state update: s0 is the word at the pointer, s1 the next one
    function automatic logic [63:0] xs_step(input logic [63:0] s0, input logic [63:0] s1);
        logic [63:0] t;
        t = s1 ^ (s1 << 31);
        return t ^ s0 ^ (t >> 11) ^ (s0 >> 30);
    endfunction

endpackage

`default_nettype wire

@@ hdl/xorshift1024_star_generator.sv @@
// Top level of the xorshift1024* generator: request sequencer around the state memories.
//
//   channel   ports                      direction  transfer
//   request   start, busy, request       in         taken when start is high and busy is low
//   result    done, result               out        valid for the one cycle done is high
//
// Seed write, set pointer, unused codes and a bit draw from a filled cache leave the sequencer
// idle: the next item can be taken in the following cycle. A word draw or a bit draw that
// refills the cache reads and writes back the state memory, then waits for the 32 x 32
// multiplier to scramble the new word. A jump steps the generator once per bit of the 1024-bit
// jump polynomial; each set bit first sweeps all 16 state words into the accumulator memory
// through one read port, and a last sweep copies it back. Reset clears the pointer and bit
// cache and marks every state word as zero. The receiver cannot stall: done is a one-cycle strobe.
`default_nettype none

module xorshift1024_star_generator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire xs1024_pkg::req_t   request,
    output logic                    done,
    output xs1024_pkg::res_t        result
);
    import xs1024_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_STEP_RD  = 3'd1;
    localparam logic [2:0] ST_STEP_WR  = 3'd2;
    localparam logic [2:0] ST_MUL_WAIT = 3'd3;
    localparam logic [2:0] ST_JMP_CHK  = 3'd4;
    localparam logic [2:0] ST_JMP_ACC  = 3'd5;
    localparam logic [2:0] ST_JMP_OUT  = 3'd6;

    localparam logic [1:0] MODE_WORD = 2'd0;
    localparam logic [1:0] MODE_BIT  = 2'd1;
    localparam logic [1:0] MODE_JUMP = 2'd2;

    localparam logic [4:0]  SWEEP_LAST = 5'd16;
    localparam logic [63:0] MASK_AFTER_TOP = 64'h4000000000000000;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic [1:0]  mode_reg;
    logic [1:0]  mode_next;
    logic [3:0]  ptr_reg;
    logic [3:0]  ptr_next;
    logic [63:0] cache_reg;
    logic [63:0] cache_next;
    logic [63:0] mask_reg;
    logic [63:0] mask_next;
    logic [9:0]  jcnt_reg;
    logic [9:0]  jcnt_next;
    logic [4:0]  sweep_reg;
    logic [4:0]  sweep_next;
    logic        done_reg;
    logic        done_next;
    res_t        res_reg;
    res_t        res_next;

    logic        accept;
    logic [3:0]  ptr_inc;
    logic [4:0]  sweep_prev;
    logic [63:0] new_word;
    logic        poly_bit;

    wr_port_t    gen_wr;
    logic [3:0]  gen_raddr0;
    logic [63:0] gen_rdata0;
    logic [63:0] gen_rdata1;
    wr_port_t    acc_wr;
    logic        acc_clear;
    logic [63:0] acc_rdata;
    logic        mul_start;
    logic        mul_done;
    logic [63:0] mul_product;

    assign accept     = start && (state_reg == ST_IDLE);
    assign ptr_inc    = ptr_reg + 4'd1;
    assign sweep_prev = sweep_reg - 5'd1;
    assign new_word   = xs_step(gen_rdata0, gen_rdata1);
    assign poly_bit   = JUMP_POLY[jcnt_reg[9:6]][jcnt_reg[5:0]];

    // State memory ports
    assign gen_raddr0 = (state_reg == ST_JMP_ACC) ? (ptr_reg + sweep_reg[3:0]) : ptr_reg;

    always_comb
    begin
        gen_wr = '0;
        if (accept && (request.req_type == REQ_WRITE))
        begin
            gen_wr.en   = 1'b1;
            gen_wr.addr = request.word_index;
            gen_wr.data = request.word_value;
        end
        else if (state_reg == ST_STEP_WR)
        begin
            gen_wr.en   = 1'b1;
            gen_wr.addr = ptr_inc;
            gen_wr.data = new_word;
        end
        else if ((state_reg == ST_JMP_OUT) && (sweep_reg != 5'd0))
        begin
            gen_wr.en   = 1'b1;
            gen_wr.addr = ptr_reg + sweep_prev[3:0];
            gen_wr.data = acc_rdata;
        end
    end

    // Accumulator memory ports
    assign acc_clear = accept && (request.req_type == REQ_JUMP);

    always_comb
    begin
        acc_wr      = '0;
        acc_wr.addr = sweep_prev[3:0];
        acc_wr.data = acc_rdata ^ gen_rdata0;
        acc_wr.en   = (state_reg == ST_JMP_ACC) && (sweep_reg != 5'd0);
    end

    // Start the scrambler on every draw step
    assign mul_start = (state_reg == ST_STEP_WR) && (mode_reg != MODE_JUMP);

    xs1024_gen_mem u_gen_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (gen_wr),
        .raddr0 (gen_raddr0),
        .raddr1 (ptr_inc),
        .rdata0 (gen_rdata0),
        .rdata1 (gen_rdata1)
    );

    xs1024_acc_mem u_acc_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (acc_clear),
        .wr    (acc_wr),
        .raddr (sweep_reg[3:0]),
        .rdata (acc_rdata)
    );

    xs1024_phi_mul u_phi_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .operand (new_word),
        .done    (mul_done),
        .product (mul_product)
    );

    // Sequence requests
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        ptr_next   = ptr_reg;
        cache_next = cache_reg;
        mask_next  = mask_reg;
        jcnt_next  = jcnt_reg;
        sweep_next = sweep_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    case (request.req_type)
                        REQ_DRAW_WORD:
                        begin
                            mode_next  = MODE_WORD;
                            state_next = ST_STEP_RD;
                        end
                        REQ_JUMP:
                        begin
                            mode_next  = MODE_JUMP;
                            jcnt_next  = '0;
                            state_next = ST_JMP_CHK;
                        end
                        REQ_DRAW_BIT:
                        begin
                            if (mask_reg == 64'd0)
                            begin
                                mode_next  = MODE_BIT;
                                state_next = ST_STEP_RD;
                            end
                            else
                            begin
                                res_next.random_bit = |(cache_reg & mask_reg);
                                mask_next           = mask_reg >> 1;
                                done_next           = 1'b1;
                            end
                        end
                        REQ_SET_PTR:
                        begin
                            ptr_next   = request.word_index;
                            cache_next = '0;
                            mask_next  = '0;
                            done_next  = 1'b1;
                        end
                        default:
                        begin
                            // seed write goes straight to memory; unused codes do nothing
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_STEP_RD:
            begin
                state_next = ST_STEP_WR;
            end
            ST_STEP_WR:
            begin
                ptr_next = ptr_inc;
                if (mode_reg == MODE_JUMP)
                begin
                    jcnt_next  = jcnt_reg + 10'd1;
                    sweep_next = '0;
                    state_next = (jcnt_reg == '1) ? ST_JMP_OUT : ST_JMP_CHK;
                end
                else
                begin
                    state_next = ST_MUL_WAIT;
                end
            end
            ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    if (mode_reg == MODE_BIT)
                    begin
                        cache_next          = mul_product;
                        mask_next           = MASK_AFTER_TOP;
                        res_next.random_bit = mul_product[63];
                    end
                    else
                    begin
                        res_next.random_word = mul_product;
                    end
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_JMP_CHK:
            begin
                sweep_next = '0;
                state_next = poly_bit ? ST_JMP_ACC : ST_STEP_RD;
            end
            ST_JMP_ACC:
            begin
                if (sweep_reg == SWEEP_LAST)
                begin
                    state_next = ST_STEP_RD;
                end
                else
                begin
                    sweep_next = sweep_reg + 5'd1;
                end
            end
            ST_JMP_OUT:
            begin
                if (sweep_reg == SWEEP_LAST)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 5'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_WORD;
            ptr_reg   <= '0;
            cache_reg <= '0;
            mask_reg  <= '0;
            jcnt_reg  <= '0;
            sweep_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            ptr_reg   <= ptr_next;
            cache_reg <= cache_next;
            mask_reg  <= mask_next;
            jcnt_reg  <= jcnt_next;
            sweep_reg <= sweep_next;
            done_reg  <= done_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

@@ hdl/xs1024_gen_mem.sv @@
// Generator state memory: 16 x 64 bits, one write port, two registered read ports.
`default_nettype none

module xs1024_gen_mem (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire xs1024_pkg::wr_port_t wr,
    input  wire logic [3:0]           raddr0,
    input  wire logic [3:0]           raddr1,
    output logic [63:0]               rdata0,
    output logic [63:0]               rdata1
);
    import xs1024_pkg::*;

    logic [63:0] mem [16];
    logic [15:0] valid_reg;
    logic [63:0] rd0_reg;
    logic [63:0] rd1_reg;
    logic        rv0_reg;
    logic        rv1_reg;

    // Mark entries written since reset; unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rv0_reg   <= 1'b0;
            rv1_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rv0_reg <= valid_reg[raddr0];
            rv1_reg <= valid_reg[raddr1];
        end
    end

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd0_reg <= mem[raddr0];
        rd1_reg <= mem[raddr1];
    end

    assign rdata0 = rv0_reg ? rd0_reg : 64'd0;
    assign rdata1 = rv1_reg ? rd1_reg : 64'd0;

endmodule

`default_nettype wire

@@ hdl/xs1024_acc_mem.sv @@
// Jump accumulator memory: 16 x 64 bits, cleared as a whole through per-entry valid bits.
`default_nettype none

module xs1024_acc_mem (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 clear,
    input  wire xs1024_pkg::wr_port_t wr,
    input  wire logic [3:0]           raddr,
    output logic [63:0]               rdata
);
    import xs1024_pkg::*;

    logic [63:0] mem [16];
    logic [15:0] valid_reg;
    logic [63:0] rd_reg;
    logic        rv_reg;

    // Drop all entries on clear, mark entries on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rv_reg <= valid_reg[raddr];
        end
    end

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_reg <= mem[raddr];
    end

    assign rdata = rv_reg ? rd_reg : 64'd0;

endmodule

`default_nettype wire

@@ hdl/xs1024_phi_mul.sv @@
// Iterative 64 x 64 multiply by the phi constant, low 64 bits, one 32 x 32 product per cycle.
`default_nettype none

module xs1024_phi_mul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] operand,
    output logic             done,
    output logic [63:0]      product
);
    import xs1024_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_HILO = 2'd2;
    localparam logic [1:0] PH_LOHI = 2'd3;

    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic        done_reg;
    logic [63:0] opnd_reg;
    logic [63:0] prod_reg;
    logic [63:0] prod_next;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    // Pick the operand halves for this phase
    always_comb
    begin
        case (phase_reg)
            PH_HILO:
            begin
                mul_a = opnd_reg[63:32];
                mul_b = PHI_MULT_LO;
            end
            PH_LOHI:
            begin
                mul_a = opnd_reg[31:0];
                mul_b = PHI_MULT_HI;
            end
            default:
            begin
                mul_a = opnd_reg[31:0];
                mul_b = PHI_MULT_LO;
            end
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // Accumulate partial products; cross terms only reach the upper half
    always_comb
    begin
        phase_next = phase_reg;
        prod_next  = prod_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    phase_next = PH_LOW;
                end
            end
            PH_LOW:
            begin
                prod_next  = mul_p;
                phase_next = PH_HILO;
            end
            PH_HILO:
            begin
                prod_next  = prod_reg + {mul_p[31:0], 32'd0};
                phase_next = PH_LOHI;
            end
            PH_LOHI:
            begin
                prod_next  = prod_reg + {mul_p[31:0], 32'd0};
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Advance phase and flag completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == PH_LOHI);
        end
    end

    // Hold operand and running product
    always_ff @(posedge clk)
    begin
        if (start && (phase_reg == PH_IDLE))
        begin
            opnd_reg <= operand;
        end
        prod_reg <= prod_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the xorshift1024* generator: directed table, then random request streams.

module tb_top;

    import xs1024_pkg::*;

    // Request codes the block must ignore
    localparam logic [2:0] REQ_SPARE_A = 3'd5;
    localparam logic [2:0] REQ_SPARE_B = 3'd6;
    localparam logic [2:0] REQ_SPARE_C = 3'd7;

    // Scrambler multiplier and 2^512 jump taps, lowest word first
    localparam logic [63:0] GOLDEN_MULT = 64'h9e3779b97f4a7c13;
    localparam logic [63:0] JUMP_TAPS [16] = '{
        64'h84242f96eca9c41d, 64'ha3c65b8776f96855, 64'h5b34a39f070b5837,
        64'h4489affce4f31a1e, 64'h2ffeeb0a48316f40, 64'hdc2d9891fe68c022,
        64'h3659132bb12fea70, 64'haac17d8efa43cab8, 64'hc4cb815590989b13,
        64'h5ee975283d71c93b, 64'h691548c86c1bd540, 64'h7910c41d10a1e6a5,
        64'h0b5fc64563b3e2a8, 64'h047f7684e9fc949d, 64'hb99181f2d8f685ca,
        64'h284600e3f30e38c3
    };

    localparam int RANDOM_ITEMS = 1850;
    localparam int MAX_PRINTED  = 40;

    typedef struct packed {
        req_t rq;
        logic typed;
        res_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t request;
    logic done;
    res_t result;

    // Fixed expectation that rides along with the item being offered
    logic typed_check;
    res_t typed_result;

    // Shadow copy of the generator
    logic [63:0] gen_state [16];
    logic [3:0]  gen_ptr;
    logic [63:0] bit_word;
    logic [63:0] bit_sel;

    res_t      owed_results [$];
    stim_row_t stim_table [$];
    int        op_count [8];
    int        errors;
    int        checked;
    int        counted;
    int        burst_left;
    int        jumps_left;

    xorshift1024_star_generator uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always #5 clk = ~clk;

    // Advance the shadow generator one step and return the scrambled word
    function automatic logic [63:0] step_generator();
        logic [63:0] s0;
        logic [63:0] s1;
        s0 = gen_state[gen_ptr];
        gen_ptr = gen_ptr + 4'd1;
        s1 = gen_state[gen_ptr];
        s1 = s1 ^ (s1 << 31);
        s1 = s1 ^ s0 ^ (s1 >> 11) ^ (s0 >> 30);
        gen_state[gen_ptr] = s1;
        return s1 * GOLDEN_MULT;
    endfunction

    // Advance the shadow generator by 2^512 steps
    function automatic void jump_generator();
        logic [63:0] acc [16];
        logic [3:0]  k;
        for (int j = 0; j < 16; j++)
            acc[j] = '0;
        for (int i = 0; i < 16; i++)
        begin
            for (int b = 0; b < 64; b++)
            begin
                if (JUMP_TAPS[i][b])
                begin
                    for (int j = 0; j < 16; j++)
                    begin
                        k = gen_ptr + 4'(j);
                        acc[j] ^= gen_state[k];
                    end
                end
                void'(step_generator());
            end
        end
        for (int j = 0; j < 16; j++)
        begin
            k = gen_ptr + 4'(j);
            gen_state[k] = acc[j];
        end
    endfunction

    // Apply one request to the shadow state and return the result it owes
    function automatic res_t generator_reply(input req_t r);
        res_t o;
        o = '0;
        case (r.req_type)
            REQ_DRAW_WORD: o.random_word = step_generator();
            REQ_WRITE:     gen_state[r.word_index] = r.word_value;
            REQ_JUMP:      jump_generator();
            REQ_DRAW_BIT:
            begin
                if (bit_sel == '0)
                begin
                    bit_word = step_generator();
                    bit_sel  = 64'h8000_0000_0000_0000;
                end
                o.random_bit = |(bit_word & bit_sel);
                bit_sel = bit_sel >> 1;
            end
            REQ_SET_PTR:
            begin
                gen_ptr  = r.word_index;
                bit_word = '0;
                bit_sel  = '0;
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("mismatch on %s at %0t: got %h, expected %h", what, $time, got, want);
    endtask

    // Predict each accepted item, check each result against the oldest prediction
    always @(posedge clk)
    begin : monitor
        res_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                want = generator_reply(request);
                if (typed_check)
                    want = typed_result;
                owed_results.push_back(want);
                op_count[request.req_type]++;
            end
            if (done)
            begin
                if (owed_results.size() == 0)
                    note_mismatch("result with nothing pending", result.random_word, '0);
                else
                begin
                    want = owed_results.pop_front();
                    checked++;
                    if (result.random_word !== want.random_word)
                        note_mismatch("random_word", result.random_word, want.random_word);
                    if (result.random_bit !== want.random_bit)
                        note_mismatch("random_bit", 64'(result.random_bit),
                                      64'(want.random_bit));
                end
            end
        end
    end

    // Pick an idle gap before the next item: mostly none, a few long, some bursts
    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 3)
        begin
            burst_left = $urandom_range(60, 10);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(15, 4);
        return $urandom_range(80, 20);
    endfunction

    // Pick a seed word: mostly random, sometimes an extreme or a single bit
    function automatic logic [63:0] pick_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(63);
            3: return ~(64'd1 << $urandom_range(63));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic issue(input req_t r, input logic typed, input res_t t);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start        <= 1'b1;
        request      <= r;
        typed_check  <= typed;
        typed_result <= t;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic send_op(input logic [2:0] op, input logic [3:0] idx, input logic [63:0] v);
        req_t r;
        r.req_type   = op;
        r.word_index = idx;
        r.word_value = v;
        issue(r, 1'b0, '0);
        if (op <= REQ_SET_PTR)
            counted++;
    endtask

    task automatic add_row(input logic [2:0] op, input logic [3:0] idx, input logic [63:0] v,
                           input logic typed, input logic [63:0] w, input logic b);
        stim_row_t row;
        row.rq.req_type         = op;
        row.rq.word_index       = idx;
        row.rq.word_value       = v;
        row.typed               = typed;
        row.want.random_word    = w;
        row.want.random_bit     = b;
        stim_table.push_back(row);
    endtask

    task automatic reseed_all();
        for (int j = 0; j < 16; j++)
            send_op(REQ_WRITE, 4'(j), pick_word());
    endtask

    initial
    begin
        int pick;
        logic [2:0] op;
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        request      = '0;
        typed_check  = 1'b0;
        typed_result = '0;
        errors       = 0;
        checked      = 0;
        counted      = 0;
        burst_left   = 0;
        jumps_left   = 12;
        for (int j = 0; j < 8; j++)
            op_count[j] = 0;
        for (int j = 0; j < 16; j++)
            gen_state[j] = '0;
        gen_ptr  = '0;
        bit_word = '0;
        bit_sel  = '0;

        // Directed table: op, index, value, typed?, word, bit
        add_row(REQ_DRAW_WORD, 4'd0,  64'h0,                 1, 64'h0, 1'b0); // zero state
        add_row(REQ_DRAW_BIT,  4'd0,  64'h0,                 1, 64'h0, 1'b0); // zero refill
        add_row(REQ_SPARE_A,   4'd15, 64'hffff_ffff_ffff_ffff, 1, 64'h0, 1'b0);
        add_row(REQ_SPARE_B,   4'd5,  64'h5555_5555_5555_5555, 1, 64'h0, 1'b0);
        add_row(REQ_SPARE_C,   4'd10, 64'haaaa_aaaa_aaaa_aaaa, 1, 64'h0, 1'b0);
        add_row(REQ_WRITE,     4'd0,  64'hffff_ffff_ffff_ffff, 1, 64'h0, 1'b0);
        add_row(REQ_WRITE,     4'd15, 64'h0,                 1, 64'h0, 1'b0);
        add_row(REQ_WRITE,     4'd1,  64'h0123_4567_89ab_cdef, 1, 64'h0, 1'b0);
        add_row(REQ_WRITE,     4'd2,  64'h8000_0000_0000_0001, 1, 64'h0, 1'b0);
        add_row(REQ_SET_PTR,   4'd15, 64'hffff_ffff_ffff_ffff, 1, 64'h0, 1'b0);
        add_row(REQ_DRAW_WORD, 4'd3,  64'h0,                 0, 64'h0, 1'b0); // pointer wraps
        add_row(REQ_DRAW_BIT,  4'd0,  64'h0,                 0, 64'h0, 1'b0); // refill
        add_row(REQ_DRAW_BIT,  4'd0,  64'h0,                 0, 64'h0, 1'b0); // from cache
        add_row(REQ_DRAW_BIT,  4'd0,  64'h0,                 0, 64'h0, 1'b0);
        add_row(REQ_SET_PTR,   4'd0,  64'h0,                 1, 64'h0, 1'b0); // empty cache
        add_row(REQ_DRAW_BIT,  4'd0,  64'h0,                 0, 64'h0, 1'b0); // refill again
        add_row(REQ_JUMP,      4'd9,  64'hdead_beef_0000_0001, 1, 64'h0, 1'b0);
        add_row(REQ_DRAW_WORD, 4'd0,  64'h0,                 0, 64'h0, 1'b0);
        add_row(REQ_DRAW_BIT,  4'd0,  64'h0,                 0, 64'h0, 1'b0); // cache kept
        add_row(REQ_WRITE,     4'd7,  64'h0,                 1, 64'h0, 1'b0);
        add_row(REQ_SET_PTR,   4'd10, 64'h0,                 1, 64'h0, 1'b0);
        add_row(REQ_DRAW_WORD, 4'd0,  64'h0,                 0, 64'h0, 1'b0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (stim_table[i])
            issue(stim_table[i].rq, stim_table[i].typed, stim_table[i].want);

        // Random streams: reseed, then mostly draw runs with seeds, pointer moves and jumps
        reseed_all();
        while (counted < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 36)
                repeat ($urandom_range(20, 1))
                    send_op(REQ_DRAW_WORD, 4'($urandom_range(15)), {$urandom(), $urandom()});
            else if (pick < 58)
                repeat ($urandom_range(100, 1))
                    send_op(REQ_DRAW_BIT, 4'($urandom_range(15)), {$urandom(), $urandom()});
            else if (pick < 67)
            begin
                if ($urandom_range(3) == 0)
                    reseed_all();
                else
                    repeat ($urandom_range(6, 1))
                        send_op(REQ_WRITE, 4'($urandom_range(15)), pick_word());
            end
            else if (pick < 75)
                send_op(REQ_SET_PTR, 4'($urandom_range(15)), {$urandom(), $urandom()});
            else if (pick < 80 && jumps_left > 0)
            begin
                jumps_left--;
                send_op(REQ_JUMP, 4'($urandom_range(15)), {$urandom(), $urandom()});
            end
            else if (pick < 88)
                send_op(3'($urandom_range(REQ_SPARE_C, REQ_SPARE_A)),
                        4'($urandom_range(15)), {$urandom(), $urandom()});
            else
            begin
                op = 3'($urandom_range(REQ_SET_PTR));
                if (op == REQ_JUMP)
                    op = REQ_DRAW_BIT;
                send_op(op, 4'($urandom_range(15)), pick_word());
            end
        end

        // Drain the outstanding results
        @(negedge clk);
        start <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (owed_results.size() != 0)
            note_mismatch("results never returned", 64'(owed_results.size()), '0);
        $display("covered %0d word draws, %0d bit draws, %0d seed writes, %0d jumps,",
                 op_count[REQ_DRAW_WORD], op_count[REQ_DRAW_BIT], op_count[REQ_WRITE],
                 op_count[REQ_JUMP]);
        $display("%0d pointer sets, %0d ignored codes; %0d results checked, %0d mismatches",
                 op_count[REQ_SET_PTR],
                 op_count[REQ_SPARE_A] + op_count[REQ_SPARE_B] + op_count[REQ_SPARE_C],
                 checked, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #25_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
